// File: rtl/assert_macros.svh
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property on the rising clock edge, off while reset is low
`define MFR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("port check failed");

// Antecedent in one cycle, consequent in the next
`define MFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("port check failed");

`endif

// File: rtl/mfr_pkg.sv
// Types and constants of the MUSCL face reconstruction block.
`default_nettype none

package mfr_pkg;

	// Reconstruction scheme codes
	typedef enum logic [1:0] {
		MODE_FIRST  = 2'd0,
		MODE_KAPPA  = 2'd1,
		MODE_MINMOD = 2'd2,
		MODE_MINABS = 2'd3
	} mfr_mode_t;

	// One request: four neighbouring cells, signed Q15.16
	typedef struct packed {
		logic signed [31:0] cell_far_left;
		logic signed [31:0] cell_left;
		logic signed [31:0] cell_right;
		logic signed [31:0] cell_far_right;
	} mfr_in_t;

	// One result: both interface states, saturated
	typedef struct packed {
		logic signed [31:0] left_face;
		logic signed [31:0] right_face;
	} mfr_out_t;

	// Divide by three: floor(y / 3) = (y * DIV3_RECIP) >> DIV3_SHIFT for y < 2**19
	localparam int unsigned DIV3_RECIP = 174763;
	localparam int unsigned DIV3_SHIFT = 19;
	// 2**16 = 3 * CHUNK_QUOT + 1, so a high chunk adds CHUNK_QUOT per unit plus itself
	localparam int unsigned CHUNK_W    = 16;
	localparam int unsigned CHUNK_QUOT = 21845;

	localparam logic signed [31:0] FACE_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] FACE_MIN = 32'sh8000_0000;

endpackage

`default_nettype wire

// File: rtl/muscl_face_reconstruction_top.sv
// MUSCL face reconstruction: hold, difference, slope, divide and result registers.
// Throughput: one request per cycle; each stage register advances when the next one frees.
// The divide by six is a split reciprocal multiply in its own stage, which sets the depth.
// Reset clears all valid flags and sets the scheme to first order; payloads are not reset.
`default_nettype none

module muscl_face_reconstruction_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire mfr_pkg::mfr_in_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output mfr_pkg::mfr_out_t      out_data
);

	// Offset of one face: sign, magnitude, and whether it still needs the divide
	typedef struct packed {
		logic        neg;
		logic        div;
		logic [33:0] raw;
	} side_t;

	function automatic logic [32:0] mag33(input logic signed [32:0] x);
		mag33 = x[32] ? 33'(-x) : 33'(x);
	endfunction

	// Work out the face offset for one side from its outer and the central difference
	function automatic side_t side_calc(
		input mfr_pkg::mfr_mode_t   mode,
		input logic signed [32:0]   outer,
		input logic signed [32:0]   central
	);
		side_t              s;
		logic signed [34:0] n;
		logic [34:0]        n_rnd;
		logic [32:0]        mag_o;
		logic [32:0]        mag_c;
		logic               pick_outer;
		logic               lim_neg;
		logic [32:0]        lim_mag;
		logic               mm_zero;
		n          = 35'(outer) + (35'(central) <<< 1);
		// |n| + 3: for negative n this is ~n + 4
		n_rnd      = n[34] ? (~n + 35'd4) : (n + 35'd3);
		mag_o      = mag33(outer);
		mag_c      = mag33(central);
		pick_outer = (mag_o < mag_c);
		lim_neg    = pick_outer ? outer[32] : central[32];
		lim_mag    = pick_outer ? mag_o : mag_c;
		mm_zero    = (outer == '0) || (central == '0) || (outer[32] != central[32]);
		s          = '0;
		unique case (mode)
			mfr_pkg::MODE_FIRST: begin
				s = '0;
			end
			mfr_pkg::MODE_KAPPA: begin
				s.neg = n[34];
				s.div = 1'b1;
				s.raw = n_rnd[33:0];
			end
			mfr_pkg::MODE_MINMOD: begin
				if (!mm_zero) begin
					s.neg = lim_neg;
					s.raw = {2'b00, lim_mag[32:1]};
				end
			end
			mfr_pkg::MODE_MINABS: begin
				s.neg = lim_neg;
				s.raw = {2'b00, lim_mag[32:1]};
			end
		endcase
		side_calc = s;
	endfunction

	// floor(raw / 6) as floor(floor(raw / 2) / 3), split in 16-bit chunks
	function automatic logic [31:0] div6(input logic [33:0] raw);
		logic [32:0] t;
		logic [16:0] hi;
		logic [15:0] lo;
		logic [17:0] y;
		logic [36:0] prod;
		logic [31:0] hq;
		t    = raw[33:1];
		hi   = t[32:mfr_pkg::CHUNK_W];
		lo   = t[mfr_pkg::CHUNK_W-1:0];
		y    = 18'(hi) + 18'(lo);
		prod = 37'(y) * 37'(mfr_pkg::DIV3_RECIP);
		hq   = 32'(hi) * 32'(mfr_pkg::CHUNK_QUOT);
		div6 = hq + 32'(prod >> mfr_pkg::DIV3_SHIFT);
	endfunction

	// Clamp a 34-bit face to the signed 32-bit range
	function automatic logic signed [31:0] sat34(input logic signed [33:0] x);
		if (x[33:31] == 3'b000 || x[33:31] == 3'b111) begin
			sat34 = x[31:0];
		end else if (x[33]) begin
			sat34 = mfr_pkg::FACE_MIN;
		end else begin
			sat34 = mfr_pkg::FACE_MAX;
		end
	endfunction

	mfr_pkg::mfr_mode_t  mode_q;

	logic                vld_s1, vld_s2, vld_s3, vld_s4, out_valid_q;
	logic                en_s1, en_s2, en_s3, en_s4, en_out;

	mfr_pkg::mfr_in_t    in_s1;
	logic signed [32:0]  dc_s2, dl_s2, dr_s2;
	logic signed [31:0]  cl_s2, cr_s2, cl_s3, cr_s3, cl_s4, cr_s4;
	side_t               l_s3, r_s3;
	logic [31:0]         lq_s4, rq_s4;
	logic                lneg_s4, rneg_s4;
	mfr_pkg::mfr_out_t   out_q;

	logic signed [32:0]  dc_c, dl_c, dr_c;
	side_t               l_c, r_c;
	logic [31:0]         lq_c, rq_c;
	logic signed [33:0]  loff_c, roff_c, lface_c, rface_c;

	// Configuration is always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= mfr_pkg::MODE_FIRST;
		end else if (cfg_valid) begin
			mode_q <= mfr_pkg::mfr_mode_t'(cfg_data);
		end
	end

	// Advance each stage when it is empty or its successor advances
	assign en_out   = !out_valid_q || out_ready;
	assign en_s4    = !vld_s4 || en_out;
	assign en_s3    = !vld_s3 || en_s4;
	assign en_s2    = !vld_s2 || en_s3;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				vld_s1 <= in_valid;
			end
			if (en_s2) begin
				vld_s2 <= vld_s1;
			end
			if (en_s3) begin
				vld_s3 <= vld_s2;
			end
			if (en_s4) begin
				vld_s4 <= vld_s3;
			end
			if (en_out) begin
				out_valid_q <= vld_s4;
			end
		end
	end

	// Stage 1: hold the request
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			in_s1 <= in_data;
		end
	end

	// Stage 2: exact differences
	assign dc_c = 33'(in_s1.cell_right) - 33'(in_s1.cell_left);
	assign dl_c = 33'(in_s1.cell_left) - 33'(in_s1.cell_far_left);
	assign dr_c = 33'(in_s1.cell_far_right) - 33'(in_s1.cell_right);

	always_ff @(posedge clk) begin
		if (en_s2 && vld_s1) begin
			dc_s2 <= dc_c;
			dl_s2 <= dl_c;
			dr_s2 <= dr_c;
			cl_s2 <= in_s1.cell_left;
			cr_s2 <= in_s1.cell_right;
		end
	end

	// Stage 3: limited slope or rounded kappa numerator per side
	assign l_c = side_calc(mode_q, dl_s2, dc_s2);
	assign r_c = side_calc(mode_q, dr_s2, dc_s2);

	always_ff @(posedge clk) begin
		if (en_s3 && vld_s2) begin
			l_s3  <= l_c;
			r_s3  <= r_c;
			cl_s3 <= cl_s2;
			cr_s3 <= cr_s2;
		end
	end

	// Stage 4: divide the kappa numerator by six
	assign lq_c = l_s3.div ? div6(l_s3.raw) : l_s3.raw[31:0];
	assign rq_c = r_s3.div ? div6(r_s3.raw) : r_s3.raw[31:0];

	always_ff @(posedge clk) begin
		if (en_s4 && vld_s3) begin
			lq_s4   <= lq_c;
			rq_s4   <= rq_c;
			lneg_s4 <= l_s3.neg;
			rneg_s4 <= r_s3.neg;
			cl_s4   <= cl_s3;
			cr_s4   <= cr_s3;
		end
	end

	// Result: apply offsets and saturate
	assign loff_c  = lneg_s4 ? -$signed({2'b00, lq_s4}) : $signed({2'b00, lq_s4});
	assign roff_c  = rneg_s4 ? -$signed({2'b00, rq_s4}) : $signed({2'b00, rq_s4});
	assign lface_c = 34'(cl_s4) + loff_c;
	assign rface_c = 34'(cr_s4) - roff_c;

	always_ff @(posedge clk) begin
		if (en_out && vld_s4) begin
			out_q.left_face  <= sat34(lface_c);
			out_q.right_face <= sat34(rface_c);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// File: rtl/mfr_checker.sv
// Port-level checker for the MUSCL face reconstruction top level, with its bind.
`default_nettype none

`include "assert_macros.svh"

module mfr_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire mfr_pkg::mfr_out_t out_data
);

	// Hold a stalled result unchanged
	`MFR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, $stable(out_data))

	// Take requests whenever no result is pending
	`MFR_ASSERT(a_ready_empty, clk, arst_n, !out_valid |-> in_ready)

	// Deliver an accepted request to the output when the output never stalls
	`MFR_ASSERT(a_latency, clk, arst_n, (in_valid && in_ready) ##1 out_ready[*4] |=> out_valid)

endmodule

bind muscl_face_reconstruction_top mfr_checker u_mfr_checker (.*);

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the MUSCL face reconstruction block.
`timescale 1ns / 1ps

module testbench;

	localparam int LATENCY     = 4;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_LIMIT = 5000;
	localparam int PHASE_ITEMS = 90;

	// One row of the directed table
	typedef struct {
		mfr_pkg::mfr_mode_t scheme;
		mfr_pkg::mfr_in_t   cells;
		bit                 has_typed;
		mfr_pkg::mfr_out_t  typed_faces;
	} stim_row_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     cfg_valid = 1'b0;
	logic     cfg_ready;
	logic [1:0] cfg_data = '0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	mfr_pkg::mfr_in_t  in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	mfr_pkg::mfr_out_t out_data;

	mfr_pkg::mfr_mode_t active_scheme = mfr_pkg::MODE_FIRST;
	mfr_pkg::mfr_out_t  pending_faces[$];
	stim_row_t stimulus_table[$];
	int        send_idle = 0;
	int        recv_stall = 0;
	int        rx_hold = 0;
	int        sent_count = 0;
	int        checked_count = 0;
	int        fail_count = 0;
	int        cycle_count = 0;

	muscl_face_reconstruction_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Saturate an exact face value to the 32-bit signed range
	function automatic logic signed [31:0] clamp_face(longint x);
		if (x > longint'(mfr_pkg::FACE_MAX))
			return mfr_pkg::FACE_MAX;
		if (x < longint'(mfr_pkg::FACE_MIN))
			return mfr_pkg::FACE_MIN;
		return x[31:0];
	endfunction

	function automatic longint magnitude(longint x);
		return (x < 0) ? -x : x;
	endfunction

	// Divide by six, to nearest with ties away from zero
	function automatic longint round_sixth(longint n);
		longint q;
		q = (magnitude(n) + 3) / 6;
		return (n < 0) ? -q : q;
	endfunction

	// Halve, truncating toward zero
	function automatic longint halve_toward_zero(longint x);
		longint q;
		q = magnitude(x) / 2;
		return (x < 0) ? -q : q;
	endfunction

	// Minmod drops the slope on a zero or a sign change; minabs keeps the smaller one
	function automatic longint limit_slope(longint outer, longint central, bit minmod);
		if (minmod && (outer == 0 || central == 0 || ((outer < 0) != (central < 0))))
			return 0;
		return (magnitude(outer) < magnitude(central)) ? outer : central;
	endfunction

	// Expected faces of one request under the given scheme
	function automatic mfr_pkg::mfr_out_t predict_faces(mfr_pkg::mfr_in_t c,
			mfr_pkg::mfr_mode_t scheme);
		longint            fl, l, r, fr, dc, dl, dr, lf, rf;
		mfr_pkg::mfr_out_t faces;
		fl = longint'(c.cell_far_left);
		l  = longint'(c.cell_left);
		r  = longint'(c.cell_right);
		fr = longint'(c.cell_far_right);
		dc = r - l;
		dl = l - fl;
		dr = fr - r;
		case (scheme)
			mfr_pkg::MODE_KAPPA: begin
				lf = l + round_sixth(dl + 2 * dc);
				rf = r - round_sixth(dr + 2 * dc);
			end
			mfr_pkg::MODE_MINMOD: begin
				lf = l + halve_toward_zero(limit_slope(dl, dc, 1'b1));
				rf = r - halve_toward_zero(limit_slope(dr, dc, 1'b1));
			end
			mfr_pkg::MODE_MINABS: begin
				lf = l + halve_toward_zero(limit_slope(dl, dc, 1'b0));
				rf = r - halve_toward_zero(limit_slope(dr, dc, 1'b0));
			end
			default: begin
				lf = l;
				rf = r;
			end
		endcase
		faces.left_face  = clamp_face(lf);
		faces.right_face = clamp_face(rf);
		return faces;
	endfunction

	function automatic logic signed [31:0] pick_edge_value();
		case ($urandom_range(0, 5))
			0: return mfr_pkg::FACE_MAX;
			1: return mfr_pkg::FACE_MIN;
			2: return 32'sd0;
			3: return -32'sd1;
			4: return 32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// Random stencil: wide noise, values clustered near a base, extremes, linear ramps and tiny values
	function automatic mfr_pkg::mfr_in_t random_stencil();
		logic signed [31:0] v[4];
		logic signed [31:0] base;
		int                 span;
		int                 kind;
		mfr_pkg::mfr_in_t   c;
		kind = $urandom_range(0, 9);
		base = $urandom;
		span = $urandom_range(0, 20);
		for (int i = 0; i < 4; i++) begin
			case (kind)
				0, 1, 2: v[i] = $urandom;
				3, 4, 5, 6: v[i] = base + (int'($urandom_range(0, 2 << span)) - (1 << span));
				7: v[i] = pick_edge_value();
				8: v[i] = base + i * span;
				default: v[i] = int'($urandom_range(0, 16)) - 8;
			endcase
		end
		c.cell_far_left  = v[0];
		c.cell_left      = v[1];
		c.cell_right     = v[2];
		c.cell_far_right = v[3];
		return c;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		fail_count++;
		$display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
	endtask

	task automatic add_row(mfr_pkg::mfr_mode_t scheme, logic signed [31:0] fl,
			logic signed [31:0] l, logic signed [31:0] r, logic signed [31:0] fr,
			bit has_typed, logic signed [31:0] lf, logic signed [31:0] rf);
		stim_row_t row;
		row.scheme                 = scheme;
		row.cells.cell_far_left    = fl;
		row.cells.cell_left        = l;
		row.cells.cell_right       = r;
		row.cells.cell_far_right   = fr;
		row.has_typed              = has_typed;
		row.typed_faces.left_face  = lf;
		row.typed_faces.right_face = rf;
		stimulus_table.push_back(row);
	endtask

	// Offer one request after a random gap and hold it until accepted
	task automatic offer_request(mfr_pkg::mfr_in_t cells, bit has_typed,
			mfr_pkg::mfr_out_t typed_faces);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= cells;
		do @(posedge clk); while (!in_ready);
		pending_faces.push_back(has_typed ? typed_faces : predict_faces(cells, active_scheme));
		sent_count++;
	endtask

	// Drop valid and wait until every expected result has arrived
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_faces.size() != 0);
	endtask

	// Change the scheme only with the pipeline empty
	task automatic write_scheme(mfr_pkg::mfr_mode_t scheme);
		drain_results();
		repeat (LATENCY + 2) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= scheme;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid     <= 1'b0;
		active_scheme  = scheme;
	endtask

	// Receiver: stall at random or for a counted hold-off, then check each result
	always @(posedge clk) begin
		mfr_pkg::mfr_out_t want;
		if (rx_hold > 0) begin
			out_ready <= 1'b0;
			rx_hold--;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall);
		end
		if (arst_n && out_valid && out_ready) begin
			if (pending_faces.size() == 0) begin
				report_mismatch("result with no request pending", out_data.left_face, '0);
			end else begin
				want = pending_faces.pop_front();
				checked_count++;
				if (out_data.left_face !== want.left_face)
					report_mismatch("left_face", out_data.left_face, want.left_face);
				if (out_data.right_face !== want.right_face)
					report_mismatch("right_face", out_data.right_face, want.right_face);
			end
		end
	end

	// Watchdog on the total run length
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("run exceeded %0d cycles", CYCLE_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	// Main sequence: reset, directed table, random phases, final drain
	initial begin
		mfr_pkg::mfr_mode_t scheme_order[4];
		mfr_pkg::mfr_out_t  no_faces;
		int                 wait_cycles;
		scheme_order[0] = mfr_pkg::MODE_FIRST;
		scheme_order[1] = mfr_pkg::MODE_KAPPA;
		scheme_order[2] = mfr_pkg::MODE_MINMOD;
		scheme_order[3] = mfr_pkg::MODE_MINABS;
		no_faces        = '0;

		// First order: reset scheme, plain copies
		add_row(mfr_pkg::MODE_FIRST, 0, 0, 0, 0, 1, 0, 0);
		add_row(mfr_pkg::MODE_FIRST, mfr_pkg::FACE_MAX, mfr_pkg::FACE_MIN,
			mfr_pkg::FACE_MAX, mfr_pkg::FACE_MIN, 1, mfr_pkg::FACE_MIN, mfr_pkg::FACE_MAX);
		add_row(mfr_pkg::MODE_FIRST, -1, 32'sh0001_8000, -32'sh0002_0000, 5, 1,
			32'sh0001_8000, -32'sh0002_0000);
		// Kappa one third: rounding ties both ways, just under a tie, saturation
		add_row(mfr_pkg::MODE_KAPPA, 0, 0, 0, 0, 1, 0, 0);
		add_row(mfr_pkg::MODE_KAPPA, -1, 0, 1, 2, 0, 0, 0);
		add_row(mfr_pkg::MODE_KAPPA, 1, 0, -1, -2, 0, 0, 0);
		add_row(mfr_pkg::MODE_KAPPA, 0, 0, 1, 1, 0, 0, 0);
		add_row(mfr_pkg::MODE_KAPPA, mfr_pkg::FACE_MIN, mfr_pkg::FACE_MAX,
			mfr_pkg::FACE_MAX, mfr_pkg::FACE_MIN, 1, mfr_pkg::FACE_MAX, mfr_pkg::FACE_MAX);
		add_row(mfr_pkg::MODE_KAPPA, mfr_pkg::FACE_MAX, mfr_pkg::FACE_MIN,
			mfr_pkg::FACE_MIN, mfr_pkg::FACE_MAX, 1, mfr_pkg::FACE_MIN, mfr_pkg::FACE_MIN);
		add_row(mfr_pkg::MODE_KAPPA, 32'sh0001_0000, 32'sh0002_0000, 32'sh0004_0000,
			32'sh0005_0000, 0, 0, 0);
		// Minmod: flat centre, sign change, odd halves, zero outer slope, extremes
		add_row(mfr_pkg::MODE_MINMOD, 5, 7, 7, 100, 1, 7, 7);
		add_row(mfr_pkg::MODE_MINMOD, 0, 10, 5, 0, 0, 0, 0);
		add_row(mfr_pkg::MODE_MINMOD, 0, 3, 10, 15, 0, 0, 0);
		add_row(mfr_pkg::MODE_MINMOD, 4, 4, 10, 10, 0, 0, 0);
		add_row(mfr_pkg::MODE_MINMOD, mfr_pkg::FACE_MIN, 0, mfr_pkg::FACE_MAX,
			mfr_pkg::FACE_MAX, 0, 0, 0);
		add_row(mfr_pkg::MODE_MINMOD, 10, 3, -4, -20, 0, 0, 0);
		// Minabs: equal magnitudes, opposite signs, extremes, negative truncation
		add_row(mfr_pkg::MODE_MINABS, 0, 4, 0, 4, 0, 0, 0);
		add_row(mfr_pkg::MODE_MINABS, 9, 10, 0, -3, 0, 0, 0);
		add_row(mfr_pkg::MODE_MINABS, mfr_pkg::FACE_MAX, mfr_pkg::FACE_MIN,
			mfr_pkg::FACE_MAX, mfr_pkg::FACE_MIN, 0, 0, 0);
		add_row(mfr_pkg::MODE_MINABS, 0, -3, -10, -11, 0, 0, 0);
		add_row(mfr_pkg::MODE_MINABS, 1, 5, 5, 9, 1, 5, 5);

		// Hold reset, then release it
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table under light idling
		send_idle  = 30;
		recv_stall = 30;
		foreach (stimulus_table[i]) begin
			if (stimulus_table[i].scheme != active_scheme)
				write_scheme(stimulus_table[i].scheme);
			offer_request(stimulus_table[i].cells, stimulus_table[i].has_typed,
				stimulus_table[i].typed_faces);
		end

		// Random phases: every scheme under every idle and stall pattern
		for (int ph = 0; ph < 16; ph++) begin
			case (ph / 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 83; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 83; end
				default: begin send_idle = 21; recv_stall = 21; end
			endcase
			write_scheme(scheme_order[ph % 4]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Back-pressure: hold the receiver off while requests keep coming
				if (ph == 2 && n == 30)
					rx_hold = 80;
				// Pause the sender until the pipeline is empty
				if (ph == 2 && n == 60)
					drain_results();
				offer_request(random_stencil(), 1'b0, no_faces);
			end
		end

		// Let the last results out, bounded
		in_valid    <= 1'b0;
		wait_cycles  = 0;
		do begin
			@(posedge clk);
			wait_cycles++;
		end while (pending_faces.size() != 0 && wait_cycles < DRAIN_LIMIT);
		repeat (LATENCY * 2) @(posedge clk);
		if (pending_faces.size() != 0)
			report_mismatch("results never delivered", pending_faces.size(), 0);

		$display("Covered %0d requests over all four schemes: rounding ties, limiter cases,",
			sent_count);
		$display("saturation and random stencils under each stall pattern; %0d results compared.",
			checked_count);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/mfr_pkg.sv
rtl/muscl_face_reconstruction_top.sv
rtl/mfr_checker.sv
sim/testbench.sv
